### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared constants, opcodes, status codes and cell command types for the
// cell-chain deque.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Number of cells in the chain, and the width of a count from 0 to DEPTH.
    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the stream payload.
    localparam int DATA_W   = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DUMP_FWD   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_DUMP_REV   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_BACK,
        CELL_PUSH_FRONT,
        CELL_POP_BACK,
        CELL_POP_FRONT,
        CELL_ROT_FWD,
        CELL_ROT_REV
    } cell_cmd_t;

    // Control bundle from the controller to the chain.
    typedef struct packed {
        cell_cmd_t          cmd;
        logic [DATA_W-1:0]  din;
    } chain_ctrl_t;

endpackage

### rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One storage cell of the chain: a value and an occupied flag. Stored values
// are packed from cell 0 (front) upward; each cycle the cell takes its next
// contents from itself, a neighbor, the front value or the broadcast data.
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  deq_pkg::cell_cmd_t      cmd,
    input  logic [31:0]             din,
    input  logic [31:0]             left_val,
    input  logic                    left_occ,
    input  logic [31:0]             right_val,
    input  logic                    right_occ,
    input  logic [31:0]             head_val,
    output logic [31:0]             val,
    output logic                    occ,
    output logic [31:0]             tap
);
    import deq_pkg::*;

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic              occ_reg;
    logic              occ_next;
    logic              is_tail;

    // This cell holds the back value when it is occupied and its right
    // neighbor is not.
    assign is_tail = occ_reg && !right_occ;

    // Next contents of the cell for each chain command.
    always_comb
    begin
        val_next = val_reg;
        occ_next = occ_reg;
        case (cmd)
            CELL_PUSH_BACK:
            begin
                if (!occ_reg && left_occ)
                begin
                    val_next = din;
                    occ_next = 1'b1;
                end
            end
            CELL_PUSH_FRONT:
            begin
                val_next = left_val;
                occ_next = left_occ;
            end
            CELL_POP_BACK:
            begin
                if (is_tail)
                begin
                    occ_next = 1'b0;
                end
            end
            CELL_POP_FRONT:
            begin
                val_next = right_val;
                occ_next = right_occ;
            end
            CELL_ROT_FWD:
            begin
                // The back cell takes the front value, the others shift down.
                if (occ_reg)
                begin
                    val_next = right_occ ? right_val : head_val;
                end
            end
            CELL_ROT_REV:
            begin
                if (occ_reg)
                begin
                    val_next = left_val;
                end
            end
            default:
            begin
                val_next = val_reg;
                occ_next = occ_reg;
            end
        endcase
    end

    // Occupied flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Stored value needs no reset.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign occ = occ_reg;
    assign tap = is_tail ? val_reg : '0;

endmodule

### rtl/deq_chain.sv
// ----------------------------------------------------------------------------
// Deque cell chain
// A row of DEPTH cells wired to their neighbors. Provides the front value
// (cell 0) and the back value (the last occupied cell) to the controller.
// ----------------------------------------------------------------------------
module deq_chain (
    input  logic                    clk,
    input  logic                    rst_n,
    input  deq_pkg::chain_ctrl_t    ctrl,
    output logic [31:0]             head_val,
    output logic [31:0]             tail_val
);
    import deq_pkg::*;

    logic [DATA_W-1:0] cell_val [DEPTH];
    logic [DATA_W-1:0] cell_tap [DEPTH];
    logic [DEPTH-1:0]  cell_occ;
    logic [DATA_W-1:0] front_in;

    // Cell 0 takes the pushed value on a front push and the back value
    // when rotating toward the back.
    assign front_in = (ctrl.cmd == CELL_PUSH_FRONT) ? ctrl.din : tail_val;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] lv;
            logic              lo;
            logic [DATA_W-1:0] rv;
            logic              ro;

            if (gi == 0)
            begin : g_first
                assign lv = front_in;
                assign lo = 1'b1;
            end
            else
            begin : g_mid
                assign lv = cell_val[gi-1];
                assign lo = cell_occ[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign rv = '0;
                assign ro = 1'b0;
            end
            else
            begin : g_inner
                assign rv = cell_val[gi+1];
                assign ro = cell_occ[gi+1];
            end

            deq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (ctrl.cmd),
                .din       (ctrl.din),
                .left_val  (lv),
                .left_occ  (lo),
                .right_val (rv),
                .right_occ (ro),
                .head_val  (head_val),
                .val       (cell_val[gi]),
                .occ       (cell_occ[gi]),
                .tap       (cell_tap[gi])
            );
        end
    endgenerate

    assign head_val = cell_val[0];

    // At most one cell drives a nonzero tap, so an OR gives the back value.
    always_comb
    begin
        tail_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_val = tail_val | cell_tap[i];
        end
    end

endmodule

### rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit values held in a chain of cells, with
// push and pop at either end and forward or reverse dumps.
// ----------------------------------------------------------------------------
// A push or pop gives one registered result transaction, so these items can be
// taken every cycle while the output side keeps up. A dump of N stored values
// gives no result for the item itself, then N results as the cell chain
// rotates by one position per result, while the output side takes them; an
// empty dump gives a single result with empty status. While a dump streams,
// s_axis_tready stays low. The store holds up to DEPTH (64) values and needs
// no clearing after reset. Opcodes 6 and 7 are accepted and give no result.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    // Input stream, tdata: opcode[2:0], value[34:3], zero pad [39:35]
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [deq_pkg::IN_W-1:0]   s_axis_tdata,
    // Output stream, tdata: value_out[31:0], occupancy[38:32], zero pad [39]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [deq_pkg::OUT_W-1:0]  m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]                 m_axis_tuser,
    output logic                       m_axis_tlast
);
    import deq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    remain_reg;
    logic [CNT_W-1:0]    remain_next;
    logic                rev_reg;
    logic                rev_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DATA_W-1:0]   out_val_reg;
    logic [DATA_W-1:0]   out_val_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic                out_last_reg;
    logic                out_last_next;
    logic [CNT_W-1:0]    out_occ_reg;
    logic [CNT_W-1:0]    out_occ_next;

    logic                out_free;
    logic                in_acc;
    logic [OPCODE_W-1:0] in_opcode;
    logic [DATA_W-1:0]   in_value;
    logic                is_full;
    logic                is_empty;
    logic                load;
    chain_ctrl_t         ctrl;
    logic [DATA_W-1:0]   head_val;
    logic [DATA_W-1:0]   tail_val;

    // Input handshake and field unpacking.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_opcode     = s_axis_tdata[OPCODE_W-1:0];
    assign in_value      = s_axis_tdata[OPCODE_W+DATA_W-1:OPCODE_W];
    assign is_full       = (count_reg == CNT_W'(DEPTH));
    assign is_empty      = (count_reg == '0);

    // Operation decode, chain command and result formation.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        rev_next        = rev_reg;
        ctrl.cmd        = CELL_HOLD;
        ctrl.din        = in_value;
        load            = 1'b0;
        out_val_next    = out_val_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_occ_next    = out_occ_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_opcode)
                        OP_PUSH_BACK, OP_PUSH_FRONT:
                        begin
                            load          = 1'b1;
                            out_val_next  = '0;
                            out_last_next = 1'b1;
                            if (is_full)
                            begin
                                out_status_next = ST_FULL;
                                out_occ_next    = count_reg;
                            end
                            else
                            begin
                                ctrl.cmd        = (in_opcode == OP_PUSH_BACK) ?
                                                  CELL_PUSH_BACK : CELL_PUSH_FRONT;
                                count_next      = count_reg + 1'b1;
                                out_status_next = ST_OK;
                                out_occ_next    = count_reg + 1'b1;
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT:
                        begin
                            load          = 1'b1;
                            out_last_next = 1'b1;
                            if (is_empty)
                            begin
                                out_val_next    = '0;
                                out_status_next = ST_EMPTY;
                                out_occ_next    = count_reg;
                            end
                            else
                            begin
                                ctrl.cmd        = (in_opcode == OP_POP_BACK) ?
                                                  CELL_POP_BACK : CELL_POP_FRONT;
                                out_val_next    = (in_opcode == OP_POP_BACK) ?
                                                  tail_val : head_val;
                                count_next      = count_reg - 1'b1;
                                out_status_next = ST_OK;
                                out_occ_next    = count_reg - 1'b1;
                            end
                        end
                        OP_DUMP_FWD, OP_DUMP_REV:
                        begin
                            if (is_empty)
                            begin
                                load            = 1'b1;
                                out_val_next    = '0;
                                out_status_next = ST_EMPTY;
                                out_last_next   = 1'b1;
                                out_occ_next    = count_reg;
                            end
                            else
                            begin
                                state_next  = S_DUMP;
                                remain_next = count_reg;
                                rev_next    = (in_opcode == OP_DUMP_REV);
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // One value per cycle while the output side can take it; a full rotation leaves the order intact.
                if (out_free)
                begin
                    ctrl.cmd        = rev_reg ? CELL_ROT_REV : CELL_ROT_FWD;
                    load            = 1'b1;
                    out_val_next    = rev_reg ? tail_val : head_val;
                    out_status_next = ST_OK;
                    out_last_next   = (remain_reg == CNT_W'(1));
                    out_occ_next    = count_reg;
                    remain_next     = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            remain_reg     <= '0;
            rev_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_val_reg    <= '0;
            out_status_reg <= ST_OK;
            out_last_reg   <= 1'b0;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            remain_reg     <= remain_next;
            rev_reg        <= rev_next;
            out_valid_reg  <= out_valid_next;
            out_val_reg    <= out_val_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    // Storage chain.
    deq_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .head_val (head_val),
        .tail_val (tail_val)
    );

    // Output packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_W - DATA_W - OCC_W)'(0), OCC_W'(out_occ_reg), out_val_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
